// ----- rtl/iolsm_pkg.sv -----
// ----------------------------------------------------------------------------
// iolsm_pkg
// Shared types, codes and constant tables of the I/O latency stats monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package iolsm_pkg;

  // Event kinds with special handling
  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_ERROR = 3'd5;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned SNUM_W     = 48;
  localparam int unsigned MIDX_W     = 4;
  localparam int unsigned BKT_IDX_W  = 5;   // enough for the largest histogram
  localparam int unsigned NUM_BOUNDS = 10;
  localparam int unsigned NUM_PCT    = 4;
  localparam int unsigned PCT_W      = 20;
  localparam int unsigned PML_W      = 10;
  localparam int unsigned PROD_W     = VALUE_W + PML_W;

  // Queue between front and back; depth is a power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] SNAP_RESET = 16'd500;
  localparam logic [PCT_W-1:0] OVER_MID   = 20'd1000000;

  // Metric codes of a snapshot
  localparam logic [3:0] MET_TOTAL     = 4'd0;
  localparam logic [3:0] MET_BYTES     = 4'd1;
  localparam logic [3:0] MET_ERRORS    = 4'd2;
  localparam logic [3:0] MET_P50       = 4'd3;
  localparam logic [3:0] MET_P95       = 4'd4;
  localparam logic [3:0] MET_P99       = 4'd5;
  localparam logic [3:0] MET_P999      = 4'd6;
  localparam logic [3:0] MET_MAX       = 4'd7;
  localparam int unsigned MET_FIXED    = 8;

  // Classified event, passed from front to back
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic                 count_kind;
    logic                 add_bytes;
    logic                 count_err;
    logic [DATA_W-1:0]    byte_count;
    logic [DATA_W-1:0]    latency;
    logic [BKT_IDX_W-1:0] bucket;
    logic                 snap;
  } ev_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_TGT,
    ST_ADD,
    ST_CMP,
    ST_OUT
  } bk_state_e;

  // Upper bound of each histogram bucket, in us
  function automatic logic [DATA_W-1:0] bkt_bound(input int unsigned i);
    logic [DATA_W-1:0] b;
    unique case (i)
      0:       b = 32'd10;
      1:       b = 32'd50;
      2:       b = 32'd100;
      3:       b = 32'd500;
      4:       b = 32'd1000;
      5:       b = 32'd5000;
      6:       b = 32'd10000;
      7:       b = 32'd50000;
      8:       b = 32'd100000;
      9:       b = 32'd500000;
      default: b = '1;
    endcase
    return b;
  endfunction

  // Reported midpoint of each bucket; buckets past the table report the cap
  function automatic logic [PCT_W-1:0] bkt_mid(input logic [BKT_IDX_W-1:0] i);
    logic [PCT_W-1:0] m;
    unique case (i)
      5'd0:    m = 20'd5;
      5'd1:    m = 20'd30;
      5'd2:    m = 20'd75;
      5'd3:    m = 20'd300;
      5'd4:    m = 20'd750;
      5'd5:    m = 20'd3000;
      5'd6:    m = 20'd7500;
      5'd7:    m = 20'd30000;
      5'd8:    m = 20'd75000;
      5'd9:    m = 20'd300000;
      5'd10:   m = 20'd750000;
      default: m = OVER_MID;
    endcase
    return m;
  endfunction

  // Permille of p50, p95, p99, p99.9
  function automatic logic [PML_W-1:0] pct_permille(input logic [1:0] k);
    logic [PML_W-1:0] p;
    unique case (k)
      2'd0:    p = 10'd500;
      2'd1:    p = 10'd950;
      2'd2:    p = 10'd990;
      default: p = 10'd999;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/iolsm_front.sv -----
// ----------------------------------------------------------------------------
// iolsm_front
// Accepts events, sorts the latency into a bucket, decodes the kind and
// decides whether the event opens a snapshot.
// ----------------------------------------------------------------------------
`default_nettype none

module iolsm_front import iolsm_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = 11,
  parameter int unsigned NUM_KINDS   = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [KIND_W-1:0] in_kind_i,
  input  wire logic [DATA_W-1:0] in_bytes_i,
  input  wire logic [DATA_W-1:0] in_lat_i,
  output logic                   rec_valid_o,
  input  wire logic              rec_ready_i,
  output ev_rec_t                rec_o
);

  logic [CFG_W-1:0]     snap_interval_q;
  logic [CFG_W-1:0]     phase_q;
  logic [CFG_W-1:0]     interval;
  logic [CFG_W:0]       phase_inc;
  logic [BKT_IDX_W-1:0] bucket;
  logic                 push;

  assign in_ready_o  = rec_ready_i;
  assign rec_valid_o = in_valid_i;
  assign push        = in_valid_i && rec_ready_i;

  // A zero interval behaves as one
  assign interval  = (snap_interval_q == '0) ? CFG_W'(1) : snap_interval_q;
  assign phase_inc = {1'b0, phase_q} + (CFG_W+1)'(1);

  // Lowest bound that the latency does not exceed; otherwise the last bucket
  always_comb begin
    bucket = BKT_IDX_W'(NUM_BUCKETS - 1);
    for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
      if ((i + 1 < NUM_BUCKETS) && (in_lat_i <= bkt_bound(i))) begin
        bucket = BKT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    rec_o.kind       = in_kind_i;
    rec_o.count_kind = (32'(in_kind_i) < NUM_KINDS);
    rec_o.add_bytes  = (in_kind_i == KIND_READ) || (in_kind_i == KIND_WRITE);
    rec_o.count_err  = (in_kind_i == KIND_ERROR);
    rec_o.byte_count = in_bytes_i;
    rec_o.latency    = in_lat_i;
    rec_o.bucket     = bucket;
    rec_o.snap       = (phase_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_interval_q <= SNAP_RESET;
      phase_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        snap_interval_q <= cfg_data_i;
      end
      if (push) begin
        phase_q <= (phase_inc >= {1'b0, interval}) ? '0 : phase_inc[CFG_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/iolsm_fifo.sv -----
// ----------------------------------------------------------------------------
// iolsm_fifo
// Short queue of classified events between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module iolsm_fifo import iolsm_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_valid_i,
  output logic         wr_ready_o,
  input  ev_rec_t      wr_data_i,
  output logic         rd_valid_o,
  input  wire logic    rd_ready_i,
  output ev_rec_t      rd_data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  ev_rec_t          mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/iolsm_back.sv -----
// ----------------------------------------------------------------------------
// iolsm_back
// Applies events to the counters and histogram, and walks the histogram to
// build and send the snapshot metric items.
// ----------------------------------------------------------------------------
`default_nettype none

module iolsm_back import iolsm_pkg::*; #(
  parameter int unsigned NUM_BUCKETS  = 11,
  parameter int unsigned NUM_KINDS    = 6,
  parameter int unsigned COUNTER_BITS = 48
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rec_valid_i,
  output logic                    rec_ready_o,
  input  ev_rec_t                 rec_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [SNUM_W-1:0]       out_snum_o,
  output logic [MIDX_W-1:0]       out_midx_o,
  output logic [VALUE_W-1:0]      out_value_o,
  output logic                    out_last_o
);

  localparam int unsigned BW     = $clog2(NUM_BUCKETS);
  localparam int unsigned KW     = $clog2(NUM_KINDS);
  localparam int unsigned NUM_MET = MET_FIXED + NUM_KINDS;
  localparam int unsigned MW     = $clog2(NUM_MET);
  localparam int unsigned CW     = COUNTER_BITS;

  bk_state_e state_q, state_d;

  logic [CW-1:0]      kind_cnt_q [NUM_KINDS];
  logic [CW-1:0]      bucket_q   [NUM_BUCKETS];
  logic [CW-1:0]      event_total_q;
  logic [CW-1:0]      error_total_q;
  logic [CW-1:0]      snap_cnt_q;
  logic [VALUE_W-1:0] byte_total_q;
  logic [DATA_W-1:0]  peak_q;

  logic [CW-1:0]      snum_q;
  logic [VALUE_W-1:0] total_q;
  logic [VALUE_W-1:0] acc_q;
  logic [PROD_W-1:0]  prod_q [NUM_PCT];
  logic [PCT_W-1:0]   pct_q  [NUM_PCT];
  logic [NUM_PCT-1:0] found_q;
  logic [BW-1:0]      idx_q;
  logic [1:0]         k_q;
  logic [MW-1:0]      m_q;

  logic               pop;
  logic               out_free;
  logic               out_load;
  logic               idx_last;
  logic               m_last;
  logic [VALUE_W:0]   byte_sum;
  logic [VALUE_W-1:0] bkt_rd;
  logic [VALUE_W:0]   total_sum;
  logic [VALUE_W:0]   acc_sum;
  logic [PROD_W-1:0]  scaled;
  logic [MW-1:0]      kidx;
  logic [VALUE_W-1:0] met_value;

  assign idx_last  = (idx_q == BW'(NUM_BUCKETS - 1));
  assign m_last    = (m_q == MW'(NUM_MET - 1));
  assign out_free  = !out_valid_o || out_ready_i;
  assign bkt_rd    = VALUE_W'(bucket_q[idx_q]);
  assign byte_sum  = {1'b0, byte_total_q} + (VALUE_W+1)'(rec_i.byte_count);
  assign total_sum = {1'b0, total_q} + {1'b0, bkt_rd};
  assign acc_sum   = {1'b0, acc_q} + {1'b0, bkt_rd};
  // acc * 1000 as shifts: 1024 - 16 - 8
  assign scaled    = PROD_W'({acc_q, 10'd0}) - PROD_W'({acc_q, 4'd0})
                   - PROD_W'({acc_q, 3'd0});
  assign kidx      = m_q - MW'(MET_FIXED);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (pop && rec_i.snap) state_d = ST_SUM;
      ST_SUM:  if (idx_last) state_d = ST_TGT;
      ST_TGT: begin
        if (k_q == 2'd3) begin
          state_d = (total_q == '0) ? ST_OUT : ST_ADD;
        end
      end
      ST_ADD:  state_d = ST_CMP;
      ST_CMP:  state_d = idx_last ? ST_OUT : ST_ADD;
      ST_OUT:  if (out_load && m_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop         = (state_q == ST_IDLE) && rec_valid_i;
    rec_ready_o = (state_q == ST_IDLE);
    out_load    = (state_q == ST_OUT) && out_free;
  end

  // Metric select for the item being loaded
  always_comb begin
    met_value = '0;
    if (32'(m_q) >= MET_FIXED) begin
      met_value = VALUE_W'(kind_cnt_q[kidx[KW-1:0]]);
    end else begin
      unique case (4'(m_q))
        MET_TOTAL:  met_value = VALUE_W'(event_total_q);
        MET_BYTES:  met_value = byte_total_q;
        MET_ERRORS: met_value = VALUE_W'(error_total_q);
        MET_P50:    met_value = VALUE_W'(pct_q[0]);
        MET_P95:    met_value = VALUE_W'(pct_q[1]);
        MET_P99:    met_value = VALUE_W'(pct_q[2]);
        MET_P999:   met_value = VALUE_W'(pct_q[3]);
        MET_MAX:    met_value = VALUE_W'(peak_q);
        default:    met_value = '0;
      endcase
    end
  end

  // Control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      event_total_q <= '0;
      error_total_q <= '0;
      snap_cnt_q    <= '0;
      byte_total_q  <= '0;
      peak_q        <= '0;
      idx_q         <= '0;
      k_q           <= '0;
      m_q           <= '0;
      out_valid_o   <= 1'b0;
      for (int i = 0; i < NUM_KINDS; i++) kind_cnt_q[i] <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) bucket_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        for (int i = 0; i < NUM_KINDS; i++) begin
          if (rec_i.count_kind && (32'(rec_i.kind) == i) && !(&kind_cnt_q[i])) begin
            kind_cnt_q[i] <= kind_cnt_q[i] + CW'(1);
          end
        end
        for (int i = 0; i < NUM_BUCKETS; i++) begin
          if ((rec_i.bucket[BW-1:0] == BW'(i)) && !(&bucket_q[i])) begin
            bucket_q[i] <= bucket_q[i] + CW'(1);
          end
        end
        if (!(&event_total_q)) event_total_q <= event_total_q + CW'(1);
        if (rec_i.count_err && !(&error_total_q)) begin
          error_total_q <= error_total_q + CW'(1);
        end
        if (rec_i.add_bytes) begin
          byte_total_q <= byte_sum[VALUE_W] ? '1 : byte_sum[VALUE_W-1:0];
        end
        if (rec_i.latency > peak_q) peak_q <= rec_i.latency;
        if (rec_i.snap && !(&snap_cnt_q)) snap_cnt_q <= snap_cnt_q + CW'(1);
        idx_q <= '0;
        k_q   <= '0;
        m_q   <= '0;
      end
      unique case (state_q)
        ST_SUM:  idx_q <= idx_last ? '0 : idx_q + BW'(1);
        ST_TGT:  k_q <= k_q + 2'd1;
        ST_CMP:  if (!idx_last) idx_q <= idx_q + BW'(1);
        default: ;
      endcase
      if (out_load) begin
        out_valid_o <= 1'b1;
        m_q         <= m_q + MW'(1);
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Snapshot datapath and output register
  always_ff @(posedge clk_i) begin
    if (pop && rec_i.snap) begin
      snum_q  <= snap_cnt_q;
      total_q <= '0;
    end
    unique case (state_q)
      ST_SUM: begin
        total_q <= total_sum[VALUE_W] ? '1 : total_sum[VALUE_W-1:0];
      end
      ST_TGT: begin
        prod_q[k_q] <= PROD_W'(total_q) * PROD_W'(pct_permille(k_q));
        if (k_q == 2'd3) begin
          acc_q   <= '0;
          found_q <= '0;
          for (int k = 0; k < NUM_PCT; k++) begin
            pct_q[k] <= (total_q == '0) ? '0 : OVER_MID;
          end
        end
      end
      ST_ADD: begin
        acc_q <= acc_sum[VALUE_W] ? '1 : acc_sum[VALUE_W-1:0];
      end
      ST_CMP: begin
        for (int k = 0; k < NUM_PCT; k++) begin
          if (!found_q[k] && (scaled >= prod_q[k])) begin
            found_q[k] <= 1'b1;
            pct_q[k]   <= bkt_mid(BKT_IDX_W'(idx_q));
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_snum_o  <= SNUM_W'(VALUE_W'(snum_q));
      out_midx_o  <= 4'(m_q);
      out_value_o <= met_value;
      out_last_o  <= m_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/io_event_latency_stats_monitor.sv -----
// ----------------------------------------------------------------------------
// io_event_latency_stats_monitor
// I/O completion statistics: per-kind counts, byte sum, errors, peak latency
// and a latency histogram, with periodic percentile snapshots.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  -------  ---------  ----------------------  ---------------------------------
//  cfg      in         cfg_valid_i/ready_o     snap_interval [15:0]
//  s_axis   in         tvalid/tready           tuser: event_kind
//                                              tdata: byte_count, latency
//  m_axis   out        tvalid/tready, tlast    tuser: metric_index
//                                              tdata: snapshot_number, value
//
// An event without a snapshot is applied while the back end stays idle. An
// event that opens a snapshot holds the back end while it sums the histogram,
// forms the target products, walks the buckets for percentiles (an add and
// a compare step each) and sends 8 + NUM_KINDS items, plus any m_axis stall.
// A two-entry queue lets the front take up to two events during that time.
// Reset clears all counters and sets snap_interval to 500; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module io_event_latency_stats_monitor import iolsm_pkg::*; #(
  parameter int unsigned NUM_BUCKETS  = 11,
  parameter int unsigned NUM_KINDS    = 6,
  parameter int unsigned COUNTER_BITS = 48
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // Configuration write
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [15:0]   cfg_data_i,      // snap_interval
  // Event stream
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [63:0]   s_axis_tdata_i,  // [31:0] byte_count, [63:32] latency
  input  wire logic [2:0]    s_axis_tuser_i,  // [2:0] event_kind
  // Snapshot metric stream
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  output logic [111:0]       m_axis_tdata_o,  // [47:0] snapshot_number, [111:48] value
  output logic [3:0]         m_axis_tuser_o,  // [3:0] metric_index
  output logic               m_axis_tlast_o   // last_item
);

  ev_rec_t fr_rec;
  ev_rec_t bk_rec;
  logic    fr_valid;
  logic    fr_ready;
  logic    bk_valid;
  logic    bk_ready;

  logic [SNUM_W-1:0]  out_snum;
  logic [VALUE_W-1:0] out_value;

  // Register writes are always taken; the user must send them only while idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  // Front: classify each event transaction and decide on a snapshot
  iolsm_front #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .NUM_KINDS   (NUM_KINDS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_kind_i   (s_axis_tuser_i),
    .in_bytes_i  (s_axis_tdata_i[31:0]),
    .in_lat_i    (s_axis_tdata_i[63:32]),
    .rec_valid_o (fr_valid),
    .rec_ready_i (fr_ready),
    .rec_o       (fr_rec)
  );

  // Queue: hold classified events while the back end walks a snapshot
  iolsm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_rec),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_rec)
  );

  // Back: update counters, compute percentiles, drive the output register
  iolsm_back #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .NUM_KINDS    (NUM_KINDS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (bk_valid),
    .rec_ready_o (bk_ready),
    .rec_i       (bk_rec),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_snum_o  (out_snum),
    .out_midx_o  (m_axis_tuser_o),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {out_value, out_snum};

endmodule

`default_nettype wire
